// ===== rtl/rlos_pkg.sv =====
// shared constants, types and controller/datapath links for the leaf split block
`default_nettype none
package rlos_pkg;

  localparam int CAPACITY = 8;
  localparam int MIN_FILL = 2;
  localparam int MAX_DIMS = 3;
  localparam int TOTAL    = CAPACITY + 1;
  localparam int IDX_W    = $clog2(TOTAL);
  localparam int CNT_W    = $clog2(TOTAL + 1);
  localparam int K_LO     = MIN_FILL;
  localparam int K_HI     = TOTAL - MIN_FILL;
  localparam int K_DEF    = TOTAL / 2;
  localparam int ACC_W    = 32 * MAX_DIMS;
  localparam int MG_W     = 32 + $clog2(2 * MAX_DIMS);

  localparam logic signed [31:0] POS_MOST = 32'sh7fffffff;
  localparam logic signed [31:0] NEG_MOST = 32'sh80000000;
  localparam logic [1:0]         DIMS_RST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_OUT, S_RANK, S_SORTED, S_SCAN, S_MUL, S_AREA, S_CMP, S_COMMIT, S_EMIT
  } state_t;

  typedef enum logic [1:0] {PR_OV, PR_LA, PR_UA} prod_t;

  typedef struct packed {
    logic             accept;
    logic             ins_out;
    logic             rank;
    logic             def_best;
    logic             scan;
    logic             mul;
    logic             last_prod;
    logic             area;
    logic             cmp;
    logic             commit;
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic [1:0]       axis;
    logic [CNT_W-1:0] k;
    logic [1:0]       chunk;
    logic [1:0]       dim;
    prod_t            prod;
  } rlos_cmd_t;

  typedef struct packed {
    logic             full;
    logic             out_free;
    logic [1:0]       nd;
    logic [CNT_W-1:0] best_k;
  } rlos_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rlos_in_if.sv =====
// insert request channel
`default_nettype none
interface rlos_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_0;
  logic signed [31:0] coord_1;
  logic signed [31:0] coord_2;
  logic        [31:0] payload;
  modport source(output valid, coord_0, coord_1, coord_2, payload, input ready);
  modport sink(input valid, coord_0, coord_1, coord_2, payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/rlos_out_if.sv =====
// result channel
`default_nettype none
interface rlos_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_coord_0;
  logic signed [31:0] out_coord_1;
  logic signed [31:0] out_coord_2;
  logic        [31:0] out_payload;
  logic               status;
  logic        [1:0]  split_axis;
  logic        [3:0]  kept_count;
  logic               last_of_run;
  modport source(output valid, out_coord_0, out_coord_1, out_coord_2, out_payload, status,
                 split_axis, kept_count, last_of_run, input ready);
  modport sink(input valid, out_coord_0, out_coord_1, out_coord_2, out_payload, status,
               split_axis, kept_count, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/rlos_ctrl.sv =====
// sequencer for insert, per-axis sort, candidate scoring and sibling emit
`default_nettype none
module rlos_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlos_pkg::rlos_sts_t sts,
  output rlos_pkg::rlos_cmd_t cmd
);
  import rlos_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [1:0]       axis, axis_next;
  logic [CNT_W-1:0] k, k_next;
  logic [1:0]       chunk, chunk_next;
  logic [1:0]       dim, dim_next;
  prod_t            prod, prod_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      axis  <= '0;
      k     <= '0;
      chunk <= '0;
      dim   <= '0;
      prod  <= PR_OV;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      axis  <= axis_next;
      k     <= k_next;
      chunk <= chunk_next;
      dim   <= dim_next;
      prod  <= prod_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    axis_next  = axis;
    k_next     = k;
    chunk_next = chunk;
    dim_next   = dim;
    prod_next  = prod;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.idx    = idx;
    cmd.axis   = axis;
    cmd.k      = k;
    cmd.chunk  = chunk;
    cmd.dim    = dim;
    cmd.prod   = prod;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.full) begin
            state_next = S_RANK;
            axis_next  = '0;
            idx_next   = '0;
          end else begin
            state_next = S_INS_OUT;
          end
        end
      end
      S_INS_OUT: begin
        if (sts.out_free) begin
          cmd.ins_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_RANK: begin
        cmd.rank = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == IDX_W'(TOTAL - 1)) begin
          idx_next   = '0;
          state_next = S_SORTED;
        end
      end
      S_SORTED: begin
        cmd.def_best = (axis == 2'd0);
        idx_next     = '0;
        k_next       = CNT_W'(K_LO);
        if (K_LO < K_HI) begin
          state_next = S_SCAN;
        end else if (axis + 2'd1 < sts.nd) begin
          axis_next  = axis + 2'd1;
          state_next = S_RANK;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == IDX_W'(TOTAL - 1)) begin
          state_next = S_MUL;
          chunk_next = '0;
          dim_next   = '0;
          prod_next  = PR_OV;
        end
      end
      S_MUL: begin
        cmd.mul       = 1'b1;
        cmd.last_prod = (chunk == 2'(MAX_DIMS - 1)) && (dim == sts.nd - 2'd1);
        chunk_next    = chunk + 2'd1;
        if (chunk == 2'(MAX_DIMS - 1)) begin
          chunk_next = '0;
          dim_next   = dim + 2'd1;
          if (dim == sts.nd - 2'd1) begin
            dim_next = '0;
            case (prod)
              PR_OV:   prod_next = PR_LA;
              PR_LA:   prod_next = PR_UA;
              default: state_next = S_AREA;
            endcase
          end
        end
      end
      S_AREA: begin
        cmd.area   = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp  = 1'b1;
        idx_next = '0;
        if (k + 1'b1 < CNT_W'(K_HI)) begin
          k_next     = k + 1'b1;
          state_next = S_SCAN;
        end else if (axis + 2'd1 < sts.nd) begin
          axis_next  = axis + 2'd1;
          state_next = S_RANK;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        idx_next   = sts.best_k[IDX_W-1:0];
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.last = (idx == IDX_W'(TOTAL - 1));
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          idx_next = idx + 1'b1;
          if (cmd.last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/rlos_dp.sv =====
// entry storage, stable rank sort, group boxes, chunked products and output register
`default_nettype none
module rlos_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data,
  input  logic signed [31:0]  in_coord_0,
  input  logic signed [31:0]  in_coord_1,
  input  logic signed [31:0]  in_coord_2,
  input  logic [31:0]         in_payload,
  input  rlos_pkg::rlos_cmd_t cmd,
  output rlos_pkg::rlos_sts_t sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [31:0]  out_coord_0,
  output logic signed [31:0]  out_coord_1,
  output logic signed [31:0]  out_coord_2,
  output logic [31:0]         out_payload,
  output logic                status,
  output logic [1:0]          split_axis,
  output logic [3:0]          kept_count,
  output logic                last_of_run
);
  import rlos_pkg::*;

  logic [1:0]         dims;
  logic [1:0]         nd;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   map [TOTAL];
  logic [IDX_W-1:0]   pos [TOTAL];
  logic signed [31:0] ent_c [TOTAL][MAX_DIMS];
  logic [31:0]        ent_p [TOTAL];
  logic [IDX_W-1:0]   ord [TOTAL];
  logic [IDX_W-1:0]   best_ord [TOTAL];
  logic [CNT_W-1:0]   best_k;
  logic [1:0]         best_axis;
  logic               have;
  logic signed [31:0] lo_l [MAX_DIMS];
  logic signed [31:0] hi_l [MAX_DIMS];
  logic signed [31:0] lo_u [MAX_DIMS];
  logic signed [31:0] hi_u [MAX_DIMS];
  logic [ACC_W-1:0]   acc, acc_nx;
  logic [31:0]        carry;
  logic [ACC_W-1:0]   ov_r, la_r, ua_r, bov;
  logic [ACC_W:0]     ar_r, bar;
  logic [MG_W-1:0]    mg_r, bmg, mg_sum;
  logic               out_free;

  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_slot;
  logic signed [31:0] in_c [3];
  logic signed [31:0] key;
  logic [TOTAL-1:0]   lt;
  logic [CNT_W-1:0]   rank;
  logic [31:0]        le [MAX_DIMS];
  logic [31:0]        ue [MAX_DIMS];
  logic [31:0]        of [MAX_DIMS];
  logic [31:0]        fac, word;
  logic [63:0]        pw;
  logic               take;
  logic               lower;

  assign nd = (dims == 2'd0) ? 2'd1 : ((dims > 2'(MAX_DIMS)) ? 2'(MAX_DIMS) : dims);
  assign out_free = !out_valid || out_ready;
  assign in_c[0] = in_coord_0;
  assign in_c[1] = in_coord_1;
  assign in_c[2] = in_coord_2;
  assign wr_slot = map[count[IDX_W-1:0]];
  assign lower   = CNT_W'(cmd.idx) < cmd.k;

  assign sts.full     = (count == CNT_W'(CAPACITY));
  assign sts.out_free = out_free;
  assign sts.nd       = nd;
  assign sts.best_k   = best_k;

  // one shared read address into the entry registers
  always_comb begin
    rd_addr = cmd.idx;
    if (cmd.scan) rd_addr = ord[cmd.idx];
    else if (cmd.emit) rd_addr = map[cmd.idx];
  end

  // stable rank: smaller key, or equal key and earlier leaf order
  always_comb begin
    key = ent_c[rd_addr][cmd.axis];
    for (int q = 0; q < TOTAL; q++) begin
      lt[q] = (ent_c[q][cmd.axis] < key) ||
              ((ent_c[q][cmd.axis] == key) && (pos[q] < pos[rd_addr]));
    end
    rank = CNT_W'($countones(lt));
  end

  always_comb begin
    logic signed [31:0] hmin, lmax;
    logic signed [32:0] o;
    mg_sum = '0;
    for (int a = 0; a < MAX_DIMS; a++) begin
      le[a] = 32'(hi_l[a] - lo_l[a]);
      ue[a] = 32'(hi_u[a] - lo_u[a]);
      hmin  = (hi_l[a] < hi_u[a]) ? hi_l[a] : hi_u[a];
      lmax  = (lo_l[a] > lo_u[a]) ? lo_l[a] : lo_u[a];
      o     = 33'(hmin) - 33'(lmax);
      of[a] = (o[32] || (o == 33'sd0)) ? 32'd0 : o[31:0];
      if (a < int'(nd)) mg_sum = mg_sum + MG_W'(le[a]) + MG_W'(ue[a]);
    end
  end

  // one 32-bit chunk of the running product per cycle
  always_comb begin
    case (cmd.prod)
      PR_OV:   fac = of[cmd.dim];
      PR_LA:   fac = le[cmd.dim];
      PR_UA:   fac = ue[cmd.dim];
      default: fac = 32'd0;
    endcase
    word   = acc[int'(cmd.chunk)*32 +: 32];
    pw     = 64'(word) * 64'(fac) + 64'(carry);
    acc_nx = acc;
    acc_nx[int'(cmd.chunk)*32 +: 32] = pw[31:0];
  end

  always_comb begin
    take = !have || (ov_r < bov) ||
           ((ov_r == bov) && ((mg_r < bmg) || ((mg_r == bmg) && (ar_r < bar))));
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      dims      <= DIMS_RST;
      count     <= '0;
      have      <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j < TOTAL; j++) begin
        map[j] <= IDX_W'(j);
        pos[j] <= IDX_W'(j);
      end
    end else begin
      if (cfg_wr_en) dims <= cfg_wr_data;
      if (cmd.accept) begin
        if (sts.full) have <= 1'b0;
        else count <= count + 1'b1;
      end
      if (cmd.cmp && take) have <= 1'b1;
      if (cmd.commit) begin
        count <= best_k;
        for (int j = 0; j < TOTAL; j++) begin
          map[j]           <= best_ord[j];
          pos[best_ord[j]] <= IDX_W'(j);
        end
      end
      if (cmd.ins_out || cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int a = 0; a < MAX_DIMS; a++) ent_c[wr_slot][a] <= in_c[a];
      ent_p[wr_slot] <= in_payload;
    end
    if (cmd.rank) ord[rank[IDX_W-1:0]] <= rd_addr;
    if (cmd.def_best) begin
      best_ord  <= ord;
      best_k    <= CNT_W'(K_DEF);
      best_axis <= 2'd0;
    end
    if (cmd.scan) begin
      acc   <= ACC_W'(1);
      carry <= '0;
      for (int a = 0; a < MAX_DIMS; a++) begin
        if (lower) begin
          lo_l[a] <= ((cmd.idx == '0) || (ent_c[rd_addr][a] < lo_l[a])) ?
                     ent_c[rd_addr][a] : lo_l[a];
          hi_l[a] <= ((cmd.idx == '0) || (ent_c[rd_addr][a] > hi_l[a])) ?
                     ent_c[rd_addr][a] : hi_l[a];
        end else begin
          lo_u[a] <= ((CNT_W'(cmd.idx) == cmd.k) || (ent_c[rd_addr][a] < lo_u[a])) ?
                     ent_c[rd_addr][a] : lo_u[a];
          hi_u[a] <= ((CNT_W'(cmd.idx) == cmd.k) || (ent_c[rd_addr][a] > hi_u[a])) ?
                     ent_c[rd_addr][a] : hi_u[a];
        end
      end
    end
    if (cmd.mul) begin
      mg_r <= mg_sum;
      if (cmd.last_prod) begin
        acc   <= ACC_W'(1);
        carry <= '0;
        case (cmd.prod)
          PR_OV:   ov_r <= acc_nx;
          PR_LA:   la_r <= acc_nx;
          default: ua_r <= acc_nx;
        endcase
      end else begin
        acc   <= acc_nx;
        carry <= (cmd.chunk == 2'(MAX_DIMS - 1)) ? 32'd0 : pw[63:32];
      end
    end
    if (cmd.area) ar_r <= (ACC_W+1)'(la_r) + (ACC_W+1)'(ua_r);
    if (cmd.cmp && take) begin
      bov       <= ov_r;
      bmg       <= mg_r;
      bar       <= ar_r;
      best_axis <= cmd.axis;
      best_k    <= cmd.k;
      best_ord  <= ord;
    end
    if (cmd.ins_out) begin
      out_coord_0 <= '0;
      out_coord_1 <= '0;
      out_coord_2 <= '0;
      out_payload <= '0;
      status      <= 1'b0;
      split_axis  <= 2'd0;
      kept_count  <= 4'(count);
      last_of_run <= 1'b1;
    end else if (cmd.emit) begin
      out_coord_0 <= (MAX_DIMS > 0) ? ent_c[rd_addr][0] : 32'sd0;
      out_coord_1 <= (MAX_DIMS > 1) ? ent_c[rd_addr][1 % MAX_DIMS] : 32'sd0;
      out_coord_2 <= (MAX_DIMS > 2) ? ent_c[rd_addr][2 % MAX_DIMS] : 32'sd0;
      out_payload <= ent_p[rd_addr];
      status      <= 1'b1;
      split_axis  <= best_axis;
      kept_count  <= 4'(best_k);
      last_of_run <= cmd.last;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.ins_out) |-> out_free) else $error("result register overwritten");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY)) else $error("leaf count beyond capacity");
  a_commit_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> count == $past(best_k)) else $error("kept count not committed");
  a_split_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> kept_count == 4'(best_k)) else $error("kept count mismatch");

endmodule
`default_nettype wire

// ===== rtl/rtree_leaf_overflow_split.sv =====
// top level of the r-tree leaf insert and overflow split block
// din carries insert requests (three Q16.16 coordinates and a payload); dout carries
// results. cfg_wr_en/cfg_wr_data set dims_used; the user must write it only while the
// block is idle (the block does not enforce this). A request is taken only in the idle
// state; a result waiting in the output register does not block the next request.
// Insert into a non-full leaf: the result is loaded into the output register as soon as
// that register frees, and the next request is taken only after that load.
// Overflow split (nd = axes in use, T = CAPACITY+1 = 9, K = T-2*MIN_FILL = 5): for each
// of the nd axes a stable rank sort (one entry a cycle), then for each of the K split
// positions a group box scan over all T entries and the 32-bit chunked product unit
// score the candidate; after that one sibling entry per cycle while dout is ready.
// A stalled dout holds the current result; the sequencer waits before each load.
// Reset (rst, synchronous) empties the leaf and sets dims_used to 2; no clearing pass.
`default_nettype none
module rtree_leaf_overflow_split (
  input  logic       clk,
  input  logic       rst,
  rlos_in_if.sink    din,
  rlos_out_if.source dout,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);
  import rlos_pkg::*;

  rlos_cmd_t cmd;
  rlos_sts_t sts;

  rlos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rlos_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_coord_0  (din.coord_0),
    .in_coord_1  (din.coord_1),
    .in_coord_2  (din.coord_2),
    .in_payload  (din.payload),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (dout.ready),
    .out_valid   (dout.valid),
    .out_coord_0 (dout.out_coord_0),
    .out_coord_1 (dout.out_coord_1),
    .out_coord_2 (dout.out_coord_2),
    .out_payload (dout.out_payload),
    .status      (dout.status),
    .split_axis  (dout.split_axis),
    .kept_count  (dout.kept_count),
    .last_of_run (dout.last_of_run)
  );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the r-tree leaf insert and overflow split block
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rlos_pkg::*;

  typedef enum logic [1:0] {RQ_INSERT, RQ_CONFIG, RQ_DRAIN} req_kind_t;

  typedef struct {
    req_kind_t          kind;
    logic [1:0]         dims;
    logic signed [31:0] c[MAX_DIMS];
    logic [31:0]        pay;
  } leaf_req_t;

  typedef struct packed {
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic [31:0]        pay;
    logic               status;
    logic [1:0]         axis;
    logic [3:0]         kept;
    logic               last;
  } leaf_res_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 700;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [1:0] cfg_wr_data;

  rlos_in_if  din();
  rlos_out_if dout();

  rtree_leaf_overflow_split dut (
    .clk(clk), .rst(rst), .din(din), .dout(dout),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // shadow leaf
  logic signed [31:0] leaf_c[TOTAL][MAX_DIMS];
  logic [31:0]        leaf_pay[TOTAL];
  int                 leaf_cnt;
  logic [1:0]         dims_reg;

  leaf_req_t pending_q[$];
  leaf_res_t sibling_q[$];
  int  error_cnt, insert_cnt, result_cnt, split_cnt, wd_cnt;
  logic in_fire;

  function automatic void sort_by_axis(input int ax, input longint cand[TOTAL][MAX_DIMS],
                                       output int ord[TOTAL]);
    int i, j, v;
    for (i = 0; i < TOTAL; i++) ord[i] = i;
    for (i = 1; i < TOTAL; i++) begin
      v = ord[i];
      j = i;
      while (j > 0 && cand[ord[j-1]][ax] > cand[v][ax]) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = v;
    end
  endfunction

  function automatic void group_bounds(input int ord[TOTAL], input int from, input int upto,
                                       input int nd, input longint cand[TOTAL][MAX_DIMS],
                                       output longint lo[MAX_DIMS], output longint hi[MAX_DIMS]);
    int a, j;
    longint v;
    for (a = 0; a < MAX_DIMS; a++) begin
      lo[a] = longint'(POS_MOST);
      hi[a] = longint'(NEG_MOST);
    end
    for (j = from; j < upto; j++)
      for (a = 0; a < nd; a++) begin
        v = cand[ord[j]][a];
        if (v < lo[a]) lo[a] = v;
        if (v > hi[a]) hi[a] = v;
      end
  endfunction

  function automatic void predict_insert(input leaf_req_t rq);
    int nd, i, a, ax, k, e, best_ax, best_k;
    int ord[TOTAL];
    int best_ord[TOTAL];
    longint cand[TOTAL][MAX_DIMS];
    logic [31:0] cp[TOTAL];
    longint llo[MAX_DIMS], lhi[MAX_DIMS], ulo[MAX_DIMS], uhi[MAX_DIMS];
    longint h, l, le, ue, mg, b_mg;
    logic [127:0] ov, la, ua, ar, b_ov, b_ar;
    bit have, take;
    leaf_res_t r;
    nd = (dims_reg == 0) ? 1 : int'(dims_reg);
    if (nd > MAX_DIMS) nd = MAX_DIMS;
    if (leaf_cnt < CAPACITY) begin
      for (a = 0; a < MAX_DIMS; a++) leaf_c[leaf_cnt][a] = rq.c[a];
      leaf_pay[leaf_cnt] = rq.pay;
      leaf_cnt++;
      r = '0;
      r.kept = 4'(leaf_cnt);
      r.last = 1'b1;
      sibling_q.push_back(r);
      return;
    end
    split_cnt++;
    for (i = 0; i < CAPACITY; i++) begin
      for (a = 0; a < MAX_DIMS; a++) cand[i][a] = longint'(leaf_c[i][a]);
      cp[i] = leaf_pay[i];
    end
    for (a = 0; a < MAX_DIMS; a++) cand[CAPACITY][a] = longint'(rq.c[a]);
    cp[CAPACITY] = rq.pay;
    have = 0; best_ax = 0; best_k = 0; b_ov = 0; b_ar = 0; b_mg = 0;
    for (ax = 0; ax < nd; ax++) begin
      sort_by_axis(ax, cand, ord);
      for (k = K_LO; k < K_HI; k++) begin
        group_bounds(ord, 0, k, nd, cand, llo, lhi);
        group_bounds(ord, k, TOTAL, nd, cand, ulo, uhi);
        ov = 1; la = 1; ua = 1; mg = 0;
        for (a = 0; a < nd; a++) begin
          h = (lhi[a] < uhi[a]) ? lhi[a] : uhi[a];
          l = (llo[a] > ulo[a]) ? llo[a] : ulo[a];
          if (h - l <= 0) begin
            ov = 0;
            break;
          end
          ov = ov * 128'(h - l);
        end
        for (a = 0; a < nd; a++) begin
          le = lhi[a] - llo[a];
          ue = uhi[a] - ulo[a];
          mg += le + ue;
          la = la * 128'(le);
          ua = ua * 128'(ue);
        end
        mg = mg * 2;
        ar = la + ua;
        take = !have || ov < b_ov || (ov == b_ov && (mg < b_mg || (mg == b_mg && ar < b_ar)));
        if (take) begin
          have = 1; b_ov = ov; b_mg = mg; b_ar = ar; best_ax = ax; best_k = k;
          best_ord = ord;
        end
      end
    end
    if (!have) begin
      best_ax = 0;
      best_k = K_DEF;
      sort_by_axis(0, cand, best_ord);
    end
    for (i = 0; i < best_k; i++) begin
      for (a = 0; a < MAX_DIMS; a++) leaf_c[i][a] = cand[best_ord[i]][a][31:0];
      leaf_pay[i] = cp[best_ord[i]];
    end
    leaf_cnt = best_k;
    for (i = best_k; i < TOTAL; i++) begin
      e = best_ord[i];
      r.c0 = cand[e][0][31:0];
      r.c1 = cand[e][1][31:0];
      r.c2 = cand[e][2][31:0];
      r.pay = cp[e];
      r.status = 1'b1;
      r.axis = 2'(best_ax);
      r.kept = 4'(best_k);
      r.last = (i == TOTAL - 1);
      sibling_q.push_back(r);
    end
  endfunction

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return POS_MOST;
      1: return NEG_MOST;
      2: return 32'sd0;
      3, 4, 5: return 32'(($urandom_range(0, 64) - 32) <<< 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_insert(input logic signed [31:0] x, input logic signed [31:0] y,
                                     input logic signed [31:0] z, input logic [31:0] p);
    leaf_req_t rq;
    rq.kind = RQ_INSERT;
    rq.dims = 0;
    rq.c[0] = x; rq.c[1] = y; rq.c[2] = z;
    rq.pay = p;
    pending_q.push_back(rq);
  endfunction

  function automatic void add_marker(input req_kind_t kind, input logic [1:0] dims);
    leaf_req_t rq;
    rq.kind = kind;
    rq.dims = dims;
    rq.c[0] = 0; rq.c[1] = 0; rq.c[2] = 0;
    rq.pay = 0;
    pending_q.push_back(rq);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_cnt++;
    end
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // monitor and shadow update
  always @(posedge clk) begin
    leaf_res_t got, want;
    if (rst) begin
      leaf_cnt = 0;
      dims_reg = DIMS_RST;
      in_fire <= 1'b0;
    end else begin
      if (cfg_wr_en) dims_reg = cfg_wr_data;
      if (dout.valid && dout.ready) begin
        result_cnt++;
        got = {dout.out_coord_0, dout.out_coord_1, dout.out_coord_2, dout.out_payload,
               dout.status, dout.split_axis, dout.kept_count, dout.last_of_run};
        if (sibling_q.size() == 0) begin
          $error("result with nothing expected: %h", got);
          error_cnt++;
        end else begin
          want = sibling_q.pop_front();
          check_field("out_coord_0", want.c0, got.c0);
          check_field("out_coord_1", want.c1, got.c1);
          check_field("out_coord_2", want.c2, got.c2);
          check_field("out_payload", want.pay, got.pay);
          check_field("status", want.status, got.status);
          check_field("split_axis", want.axis, got.axis);
          check_field("kept_count", want.kept, got.kept);
          check_field("last_of_run", want.last, got.last);
        end
      end
      if (din.valid && din.ready) begin
        leaf_req_t rq;
        rq.kind = RQ_INSERT;
        rq.dims = 0;
        rq.c[0] = din.coord_0; rq.c[1] = din.coord_1; rq.c[2] = din.coord_2;
        rq.pay = din.payload;
        insert_cnt++;
        predict_insert(rq);
      end
      in_fire <= din.valid && din.ready;
      if ((din.valid && din.ready) || (dout.valid && dout.ready) || cfg_wr_en) wd_cnt = 0;
      else wd_cnt++;
      if (wd_cnt >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // request driver: bursts and gaps, config only once the leaf is quiet
  int burst_left, gap_left, quiet;
  always @(negedge clk) begin
    leaf_req_t hd;
    logic nv, nw;
    nv = din.valid && !in_fire;
    nw = 1'b0;
    if (rst) begin
      nv = 1'b0;
    end else if (!nv) begin
      if (sibling_q.size() == 0 && !in_fire) quiet++;
      else quiet = 0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        hd = pending_q[0];
        if (hd.kind == RQ_INSERT) begin
          void'(pending_q.pop_front());
          nv = 1'b1;
          din.coord_0 <= hd.c[0];
          din.coord_1 <= hd.c[1];
          din.coord_2 <= hd.c[2];
          din.payload <= hd.pay;
          if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else if (quiet >= 8) begin
          void'(pending_q.pop_front());
          if (hd.kind == RQ_CONFIG) begin
            nw = 1'b1;
            cfg_wr_data <= hd.dims;
          end
        end
      end
    end
    din.valid <= nv;
    cfg_wr_en <= nw;
  end

  // result stall pattern: alternating runs, with an occasional long clear stretch
  int ready_left;
  always @(negedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
    end else if (dout.ready) begin
      dout.ready <= 1'b0;
      ready_left = $urandom_range(0, 6);
    end else begin
      dout.ready <= 1'b1;
      ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 20);
    end
  end

  initial begin
    logic [1:0] phase_dims[6];
    int p, n;
    phase_dims = '{2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd3};
    rst = 1'b1;
    din.valid = 1'b0;
    din.coord_0 = 0; din.coord_1 = 0; din.coord_2 = 0; din.payload = 0;
    dout.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 0;
    error_cnt = 0; insert_cnt = 0; result_cnt = 0; split_cnt = 0; wd_cnt = 0;
    burst_left = 1; gap_left = 0; quiet = 0; ready_left = 0;

    // extremes fill the leaf, ninth request forces a split
    add_insert(POS_MOST, NEG_MOST, 32'sd0, 32'h0);
    add_insert(NEG_MOST, POS_MOST, POS_MOST, 32'hffffffff);
    add_insert(32'sd0, 32'sd0, NEG_MOST, 32'h1);
    add_insert(32'sd1, -32'sd1, 32'sd1, 32'h80000000);
    add_insert(POS_MOST, POS_MOST, POS_MOST, 32'h7fffffff);
    add_insert(NEG_MOST, NEG_MOST, NEG_MOST, 32'h55555555);
    add_insert(32'sh00010000, 32'shffff0000, 32'sd0, 32'haaaaaaaa);
    add_insert(32'sh00010000, 32'shffff0000, 32'sd0, 32'h12345678);
    add_insert(32'sd0, 32'sd0, 32'sd0, 32'hdeadbeef);
    // identical points: all scores tie, stable order decides
    for (int i = 0; i < 10; i++) add_insert(32'sh00050000, 32'sh00050000, 32'sd7, i);

    for (p = 0; p < 6; p++) begin
      if (p > 0) add_marker(RQ_CONFIG, phase_dims[p]);
      for (n = 0; n < 67; n++) begin
        if (p == 2 && n == 30) add_marker(RQ_DRAIN, 0);
        add_insert(pick_coord(), pick_coord(), pick_coord(), $urandom);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (pending_q.size() == 0 && !din.valid && sibling_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("inserted %0d points, %0d overflow splits, %0d results checked",
             insert_cnt, split_cnt, result_cnt);
    $display("axis settings 2, 1, 3, 0 (as 1), 2, 3 with random stalls on both channels");
    if (error_cnt == 0 && sibling_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/rlos_pkg.sv
rtl/rlos_in_if.sv
rtl/rlos_out_if.sv
rtl/rlos_ctrl.sv
rtl/rlos_dp.sv
rtl/rtree_leaf_overflow_split.sv
verif/testbench.sv
